FILE: sv/idr_pkg.sv
// Package for the 64-bit integer divider: widths, status codes, control structs.
package idr_pkg;

    // Datapath width; ports stay 64 bits and carry zeros above it
    localparam int DATA_WIDTH = 64;
    localparam int PORT_W     = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // Sequencer to divide unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Divide unit back to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Two's complement negate when neg is set
    function automatic logic [DATA_WIDTH-1:0] cond_negate(
        input logic [DATA_WIDTH-1:0] v,
        input logic                  neg
    );
        logic [DATA_WIDTH-1:0] res;
        res = neg ? (~v + DATA_WIDTH'(1)) : v;
        return res;
    endfunction

endpackage

FILE: sv/idr_div_unit.sv
// Radix-2 restoring divide unit: one quotient bit per cycle over unsigned magnitudes.
module idr_div_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  idr_pkg::div_ctrl_t              ctrl,
    input  logic [idr_pkg::DATA_WIDTH-1:0]  numer,
    input  logic [idr_pkg::DATA_WIDTH-1:0]  denom,
    output idr_pkg::div_stat_t              stat,
    output logic [idr_pkg::DATA_WIDTH-1:0]  quo,
    output logic [idr_pkg::DATA_WIDTH-1:0]  rem
);
    import idr_pkg::*;

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;   // dividend bits shift out, quotient bits in
    logic [DATA_WIDTH-1:0] den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    // One shift-and-subtract step
    always_comb begin
        shifted  = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff     = shifted - {1'b0, den_reg};
        ge       = ~diff[DATA_WIDTH];
        rem_next = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
        quo_next = {quo_reg[DATA_WIDTH-2:0], ge};
    end

    // Control: step counter, busy and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

FILE: sv/int64_divide_remainder.sv
// Top level of the 64-bit signed/unsigned integer divider with its sequencer.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | s_valid s_ready s_kind s_dividend s_divisor | in
//  result  | m_valid m_ready m_quotient m_remainder m_status | out
//
// From accept to result valid a request goes through these steps: operand magnitudes are
// formed at accept, the divide unit is loaded, 64 restoring steps run (one
// quotient bit each), the sequencer sees the done flag, and the sign fixup is
// applied into the result register. A zero divisor goes straight to the result.
// Reset is synchronous on aresetn and clears the sequencer and valid flags.
// The block takes no new request until the result has been taken; a stalled
// m_ready holds the result in the output register.
module int64_divide_remainder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [idr_pkg::PORT_W-1:0]  s_dividend,
    input  logic [idr_pkg::PORT_W-1:0]  s_divisor,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [idr_pkg::PORT_W-1:0]  m_quotient,
    output logic [idr_pkg::PORT_W-1:0]  m_remainder,
    output logic [1:0]                  m_status
);
    import idr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIX  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    state_t                state_reg, state_next;
    logic                  kind_reg;
    logic [DATA_WIDTH-1:0] a_reg, b_reg;
    logic [DATA_WIDTH-1:0] mag_a_reg, mag_b_reg;
    logic                  neg_a_reg, neg_b_reg;
    logic [DATA_WIDTH-1:0] q_reg, r_reg;
    status_t               status_reg;

    logic                  accept;
    logic                  out_take;
    logic [DATA_WIDTH-1:0] in_a, in_b;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [DATA_WIDTH-1:0] div_q, div_r;

    assign accept   = s_valid && s_ready;
    assign out_take = m_valid && m_ready;
    assign in_a     = s_dividend[DATA_WIDTH-1:0];
    assign in_b     = s_divisor[DATA_WIDTH-1:0];
    assign div_ctrl.start = (state_reg == ST_PREP);

    idr_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .numer   (mag_a_reg),
        .denom   (mag_b_reg),
        .stat    (div_stat),
        .quo     (div_q),
        .rem     (div_r)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = (in_b == '0) ? ST_OUT : ST_PREP;
            end
            ST_PREP: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) state_next = ST_FIX;
            end
            ST_FIX:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Operand capture, magnitudes, sign fixup and result registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_kind;
            a_reg      <= in_a;
            b_reg      <= in_b;
            // magnitudes are ready before the divide unit loads them
            neg_a_reg  <= s_kind & in_a[DATA_WIDTH-1];
            neg_b_reg  <= s_kind & in_b[DATA_WIDTH-1];
            mag_a_reg  <= cond_negate(in_a, s_kind & in_a[DATA_WIDTH-1]);
            mag_b_reg  <= cond_negate(in_b, s_kind & in_b[DATA_WIDTH-1]);
            // zero divisor: all-ones quotient, dividend as remainder
            q_reg      <= '1;
            r_reg      <= in_a;
            status_reg <= STATUS_DIV_ZERO;
        end
        if (state_reg == ST_FIX) begin
            q_reg <= cond_negate(div_q, neg_a_reg ^ neg_b_reg);
            r_reg <= cond_negate(div_r, neg_a_reg);
            // most negative over minus one wraps; flag it
            if (kind_reg && a_reg == SIGN_BIT && b_reg == '1) begin
                status_reg <= STATUS_OVERFLOW;
            end else begin
                status_reg <= STATUS_OK;
            end
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign m_quotient  = PORT_W'(q_reg);
    assign m_remainder = PORT_W'(r_reg);
    assign m_status    = status_reg;

    // Checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while result pending");

    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_b == '0) |=> (m_valid && m_status == STATUS_DIV_ZERO))
        else $error("zero divisor not reported next cycle");

    a_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_OUT) |-> !div_stat.busy)
        else $error("divide unit busy outside a division");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divide unit done outside divide state");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_quotient) && $stable(m_remainder)))
        else $error("result changed while stalled");

endmodule
